@@ hdl/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sst_pkg.sv @@
package sst_pkg;

  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  cap;
    logic                  shift;
    logic                  ins;
    logic [VALUE_BITS-1:0] cmp_val;
    logic [VALUE_BITS-1:0] ins_val;
  } sst_ctrl_t;

endpackage

@@ hdl/sst_cell.sv @@
module sst_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  sst_pkg::sst_ctrl_t             ctrl,
  input  logic [sst_pkg::IDX_W-1:0]      idx,
  input  logic [sst_pkg::CNT_W-1:0]      fill,
  input  logic                           found_in,
  input  logic [sst_pkg::VALUE_BITS-1:0] upper,
  output logic [sst_pkg::VALUE_BITS-1:0] entry,
  output logic                           found_out
);
  import sst_pkg::*;

  logic match;
  logic in_use;
  logic at_tail;

  assign in_use    = CNT_W'(idx) < fill;
  assign at_tail   = CNT_W'(idx) == fill;
  // found anywhere at or below this cell
  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cap) begin
      match <= in_use && (entry == ctrl.cmp_val);
    end
  end

  // remove pulls upper entries down from the hit; insert writes tail
  always_ff @(posedge clk) begin
    if (ctrl.shift && found_out) begin
      entry <= upper;
    end else if (ctrl.ins && at_tail) begin
      entry <= ctrl.ins_val;
    end
  end

endmodule

@@ hdl/small_set_table.sv @@
// channel   | handshake            | payload
// ----------+----------------------+------------------------
// request   | in_valid / in_ready  | kind, value
// result    | out_valid / out_ready| hit, dropped, count
//
// a request is done in steps: the accept edge registers a compare in every cell,
// the update edge applies the shift-down or tail write and loads the result.
// the update edge waits while a previous result is still held on the output.
// in_ready is high whenever no request is in flight.
// synchronous reset empties the table; no clearing pass is needed.
module small_set_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sst_pkg::KIND_W-1:0]     kind,
  input  logic [31:0]                    value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic                           dropped,
  output logic [sst_pkg::CNT_W-1:0]      count
);
  import sst_pkg::*;

  state_t                state, state_next;
  logic [CNT_W-1:0]      fill_count, fill_count_next;
  logic [KIND_W-1:0]     req_kind;
  logic [VALUE_BITS-1:0] req_value;
  logic                  accept, upd;
  logic                  found_hit, full;
  logic                  do_ins, do_rem, drop;
  sst_ctrl_t             ctrl;

  logic [VALUE_BITS-1:0] entry [CAPACITY];
  logic [CAPACITY:0]     found;

  assign accept = in_valid && in_ready;
  assign full   = fill_count == CNT_W'(CAPACITY);
  assign found_hit = found[CAPACITY];
  assign found[0]  = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    upd        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          upd        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= kind;
      req_value <= value[VALUE_BITS-1:0];
    end
  end

  assign do_ins = upd && (req_kind == KIND_INSERT) && !found_hit && !full;
  assign drop   = (req_kind == KIND_INSERT) && !found_hit && full;
  assign do_rem = upd && (req_kind == KIND_REMOVE) && found_hit;

  always_comb begin
    fill_count_next = fill_count;
    if (do_ins) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (do_rem) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    ctrl.cap     = accept;
    ctrl.shift   = do_rem;
    ctrl.ins     = do_ins;
    ctrl.cmp_val = value[VALUE_BITS-1:0];
    ctrl.ins_val = req_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] upper;
    if (i == CAPACITY - 1) begin : g_last
      assign upper = entry[i];
    end else begin : g_mid
      assign upper = entry[i+1];
    end
    sst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .idx       (IDX_W'(i)),
      .fill      (fill_count),
      .found_in  (found[i]),
      .upper     (upper),
      .entry     (entry[i]),
      .found_out (found[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      hit     <= found_hit;
      dropped <= drop;
      count   <= fill_count_next;
    end
  end

endmodule

@@ hdl/sst_checker.sv @@
`include "assert_macros.svh"

module sst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       hit,
  input logic                       dropped,
  input logic [sst_pkg::CNT_W-1:0]  count
);
  import sst_pkg::*;

  `SST_ASSERT_NOW(a_count_cap, out_valid, count <= CNT_W'(CAPACITY), "count above capacity")

  `SST_ASSERT_NOW(a_drop_miss, out_valid && dropped, !hit, "dropped insert reported a hit")

  `SST_ASSERT_NOW(a_drop_full, out_valid && dropped, count == CNT_W'(CAPACITY),
                  "dropped insert with room left")

  `SST_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready,
                   "second request taken while one is in flight")

endmodule

bind small_set_table sst_checker u_sst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .dropped   (dropped),
  .count     (count)
);
